/* design/drce_pkg.sv */
package drce_pkg;

	localparam int unsigned FRAME_BITS = 24;
	localparam int unsigned PRE_LEN    = 8;

	localparam logic [7:0] SYM_S     = 8'h53;
	localparam logic [7:0] SYM_T     = 8'h54;
	localparam logic [7:0] SYM_END   = 8'h2B;
	localparam logic [7:0] SHORT_RST = 8'd170;

	localparam logic [13:0] ADDR_ODD_MASK = 14'b10_1010_1010_1010;
	localparam logic [5:0]  LVL_EVEN_MASK = 6'b01_0101;

	localparam logic [1:0] STYLE_INSTANT = 2'd0;
	localparam logic [1:0] STYLE_FADE    = 2'd1;

	localparam logic [1:0] FADE_INSTANT = 2'b01;
	localparam logic [1:0] FADE_GRADUAL = 2'b11;

	typedef struct packed {
		logic [4:0] system_number;
		logic [3:0] channel_number;
		logic [3:0] dim_level;
		logic [1:0] dim_style;
	} cmd_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic       bad_args;
	} res_t;

	// One classified command: frame bits in send order, MSB goes first
	typedef struct packed {
		logic                  bad;
		logic [FRAME_BITS-1:0] frame;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PRE,
		BK_BITS,
		BK_END
	} back_state_t;

endpackage

/* design/dimmer_rf_remote_code_encoder.sv */
// Dimmer RF remote code encoder. Pulse start with a command while busy is low;
// up to two commands are held in a queue ahead of the frame sequencer, and
// busy is high while that queue is full. Each symbol byte comes out on result
// for one cycle with result_valid high and cannot be held off. A valid
// command sends 37 to 45 bytes (eight preamble bytes, one byte per zero and
// two per one of the 24 frame bits, of which 4 to 12 are ones, one end byte),
// emitted by the sequencer at one byte per cycle; a rejected command gives
// one flagged result.
// Write short_symbol_byte through cfg_we/cfg_wdata only while idle.
module dimmer_rf_remote_code_encoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  drce_pkg::cmd_t cmd,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	output logic           result_valid,
	output drce_pkg::res_t result
);
	import drce_pkg::*;

	logic [7:0] short_q;
	logic       push;
	logic       pop;
	logic       full;
	logic       not_empty;
	job_t       push_job;
	job_t       head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			short_q <= SHORT_RST;
		else if (cfg_we)
			short_q <= cfg_wdata;
	end

	assign busy = full;

	drce_front u_front (
		.start (start),
		.full  (full),
		.cmd   (cmd),
		.push  (push),
		.job   (push_job)
	);

	drce_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (full),
		.not_empty (not_empty),
		.head      (head)
	);

	drce_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.short_byte   (short_q),
		.not_empty    (not_empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

/* design/drce_front.sv */
module drce_front (
	input  logic          start,
	input  logic          full,
	input  drce_pkg::cmd_t cmd,
	output logic          push,
	output drce_pkg::job_t job
);
	import drce_pkg::*;

	logic        bad;
	logic [3:0]  sys_m1;
	logic [9:0]  chan_hot;
	logic [13:0] addr;
	logic [3:0]  lv;
	logic [1:0]  fade;
	logic [5:0]  lcode;
	logic [5:0]  lcode_rev;
	logic        pa_odd;
	logic        pa_even;
	logic        pl_even;
	logic        pl_odd;

	always_comb begin
		bad = (cmd.system_number < 5'd1) || (cmd.system_number > 5'd16)
			|| (cmd.channel_number < 4'd1) || (cmd.channel_number > 4'd10)
			|| (cmd.dim_level > 4'd10)
			|| ((cmd.dim_style != STYLE_INSTANT) && (cmd.dim_style != STYLE_FADE));

		sys_m1 = 4'(cmd.system_number - 5'd1);

		// channel c lights bit 9-c, channel ten lights bit 9
		chan_hot = '0;
		if (cmd.channel_number == 4'd10)
			chan_hot[9] = 1'b1;
		else
			chan_hot = 10'b10_0000_0000 >> cmd.channel_number;

		addr = {sys_m1, chan_hot};

		unique case (cmd.dim_level)
			4'd0:    lv = 4'd10;
			4'd10:   lv = 4'd0;
			default: lv = cmd.dim_level;
		endcase
		fade  = (cmd.dim_style == STYLE_FADE) ? FADE_GRADUAL : FADE_INSTANT;
		lcode = {fade, lv};

		// level bits go out LSB first
		for (int i = 0; i < 6; i++)
			lcode_rev[i] = lcode[5 - i];

		// parity symbol is a one when its count is even
		pa_odd  = ~^(addr & ADDR_ODD_MASK);
		pa_even = ~^(addr & ~ADDR_ODD_MASK);
		pl_even = ~^(lcode & LVL_EVEN_MASK);
		pl_odd  = ~^(lcode & ~LVL_EVEN_MASK);

		job.bad   = bad;
		job.frame = {addr, pa_odd, pa_even, lcode_rev, pl_even, pl_odd};
		push      = start && !full;
	end

endmodule

/* design/drce_queue.sv */
module drce_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  drce_pkg::job_t push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output drce_pkg::job_t head
);
	import drce_pkg::*;

	job_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !not_empty))
		else $error("queue read while empty");

endmodule

/* design/drce_back.sv */
module drce_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     short_byte,
	input  logic           not_empty,
	input  drce_pkg::job_t head,
	output logic           pop,
	output logic           result_valid,
	output drce_pkg::res_t result
);
	import drce_pkg::*;

	back_state_t           state_q, state_d;
	logic [2:0]            pre_cnt_q, pre_cnt_d;
	logic [4:0]            idx_q, idx_d;
	logic                  half_q, half_d;
	logic [FRAME_BITS-1:0] bits_q, bits_d;
	logic                  vld_q, vld_d;
	res_t                  res_q, res_d;

	assign result_valid = vld_q;
	assign result       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			pre_cnt_q <= '0;
			idx_q     <= '0;
			half_q    <= 1'b0;
			vld_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			pre_cnt_q <= pre_cnt_d;
			idx_q     <= idx_d;
			half_q    <= half_d;
			vld_q     <= vld_d;
		end
	end

	always_ff @(posedge clk) begin
		bits_q <= bits_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		pre_cnt_d = pre_cnt_q;
		idx_d     = idx_q;
		half_d    = half_q;
		bits_d    = bits_q;
		vld_d     = 1'b0;
		res_d     = res_q;
		pop       = 1'b0;

		unique case (state_q)
			BK_IDLE: begin
				if (not_empty) begin
					pop   = 1'b1;
					vld_d = 1'b1;
					if (head.bad) begin
						res_d = '{tx_byte: 8'd0, last: 1'b1, bad_args: 1'b1};
					end else begin
						res_d     = '{tx_byte: SYM_S, last: 1'b0, bad_args: 1'b0};
						bits_d    = head.frame;
						pre_cnt_d = 3'd1;
						state_d   = BK_PRE;
					end
				end
			end
			BK_PRE: begin
				vld_d = 1'b1;
				if (pre_cnt_q == 3'(PRE_LEN - 1)) begin
					res_d   = '{tx_byte: short_byte, last: 1'b0, bad_args: 1'b0};
					idx_d   = '0;
					half_d  = 1'b0;
					state_d = BK_BITS;
				end else begin
					res_d     = '{tx_byte: SYM_T, last: 1'b0, bad_args: 1'b0};
					pre_cnt_d = pre_cnt_q + 3'd1;
				end
			end
			BK_BITS: begin
				vld_d = 1'b1;
				if (bits_q[FRAME_BITS-1]) begin
					res_d  = '{tx_byte: SYM_T, last: 1'b0, bad_args: 1'b0};
					half_d = ~half_q;
				end else begin
					res_d = '{tx_byte: short_byte, last: 1'b0, bad_args: 1'b0};
				end
				// advance once the bit's symbol is complete
				if (!bits_q[FRAME_BITS-1] || half_q) begin
					half_d = 1'b0;
					bits_d = bits_q << 1;
					idx_d  = idx_q + 5'd1;
					if (idx_q == 5'(FRAME_BITS - 1))
						state_d = BK_END;
				end
			end
			BK_END: begin
				vld_d   = 1'b1;
				res_d   = '{tx_byte: SYM_END, last: 1'b1, bad_args: 1'b0};
				state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	a_bad_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.bad_args |-> result.last && (result.tx_byte == 8'd0))
		else $error("rejected command result malformed");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == BK_IDLE))
		else $error("queue read while frame in progress");

	a_end_after_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_END) |-> $past(state_q) == BK_BITS)
		else $error("end symbol not preceded by frame bits");

	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> state_q == BK_IDLE)
		else $error("last result while frame still running");

endmodule

/* dv/dimmer_rf_remote_code_encoder_tb.sv */
module dimmer_rf_remote_code_encoder_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import drce_pkg::*;

	class frame_scoreboard;
		logic [7:0] short_symbol;
		res_t       expected_bytes[$];
		int         fail_count;

		function new();
			short_symbol = SHORT_RST;
			fail_count   = 0;
		endfunction

		function void push_byte(logic [7:0] b, logic is_last);
			res_t r;
			r.tx_byte  = b;
			r.last     = is_last;
			r.bad_args = 1'b0;
			expected_bytes.push_back(r);
		endfunction

		// A one goes out as two T bytes, a zero as the short symbol
		function void push_bit(logic one);
			if (one) begin
				push_byte(SYM_T, 1'b0);
				push_byte(SYM_T, 1'b0);
			end else begin
				push_byte(short_symbol, 1'b0);
			end
		endfunction

		// Predict the whole frame for one accepted command transaction
		function void note_command(cmd_t c);
			res_t        r;
			logic [13:0] addr;
			logic [3:0]  lv;
			logic [1:0]  fade;
			logic [5:0]  lvl_code;
			logic        par_odd;
			logic        par_even;
			int          pos;
			if (c.system_number < 5'd1 || c.system_number > 5'd16 ||
			    c.channel_number < 4'd1 || c.channel_number > 4'd10 ||
			    c.dim_level > 4'd10 || c.dim_style > STYLE_FADE) begin
				r.tx_byte  = 8'h00;
				r.last     = 1'b1;
				r.bad_args = 1'b1;
				expected_bytes.push_back(r);
				return;
			end
			pos  = (c.channel_number == 4'd10) ? 9 : 9 - int'(c.channel_number);
			addr = '0;
			addr[13:10] = 4'(c.system_number - 5'd1);
			addr[pos]   = 1'b1;
			push_byte(SYM_S, 1'b0);
			for (int i = 0; i < 6; i++)
				push_byte(SYM_T, 1'b0);
			push_byte(short_symbol, 1'b0);
			par_odd  = 1'b0;
			par_even = 1'b0;
			for (int i = 13; i >= 0; i--) begin
				if (i % 2 == 1)
					par_odd ^= addr[i];
				else
					par_even ^= addr[i];
				push_bit(addr[i]);
			end
			// even count of ones sends TT
			push_bit(~par_odd);
			push_bit(~par_even);
			if (c.dim_level == 4'd0)
				lv = 4'd10;
			else if (c.dim_level == 4'd10)
				lv = 4'd0;
			else
				lv = c.dim_level;
			fade     = (c.dim_style == STYLE_FADE) ? FADE_GRADUAL : FADE_INSTANT;
			lvl_code = {fade, lv};
			par_odd  = 1'b0;
			par_even = 1'b0;
			for (int i = 0; i < 6; i++) begin
				if (i % 2 == 0)
					par_even ^= lvl_code[i];
				else
					par_odd ^= lvl_code[i];
				push_bit(lvl_code[i]);
			end
			push_bit(~par_even);
			push_bit(~par_odd);
			push_byte(SYM_END, 1'b1);
		endfunction

		function void check_symbol(res_t got);
			res_t want;
			if (expected_bytes.size() == 0) begin
				$error("unexpected result: tx_byte %0h last %0b bad_args %0b",
				       got.tx_byte, got.last, got.bad_args);
				fail_count++;
				return;
			end
			want = expected_bytes.pop_front();
			if (got.tx_byte !== want.tx_byte) begin
				$error("tx_byte: expected %0h, actual %0h", want.tx_byte, got.tx_byte);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				fail_count++;
			end
			if (got.bad_args !== want.bad_args) begin
				$error("bad_args: expected %0b, actual %0b", want.bad_args, got.bad_args);
				fail_count++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void flag_leftovers();
			if (expected_bytes.size() != 0) begin
				$error("%0d expected results never arrived", expected_bytes.size());
				fail_count++;
			end
		endfunction
	endclass

	localparam int DRAIN_LIMIT = 4000;
	localparam int SETTLE      = 64;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	cmd_t       cmd = '0;
	logic       cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	logic       result_valid;
	res_t       result;

	frame_scoreboard frames = new();

	always #5 clk = ~clk;

	dimmer_rf_remote_code_encoder u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	// Note the command before checking, so a same-edge result still finds it
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				frames.note_command(cmd);
			if (result_valid)
				frames.check_symbol(result);
		end
	end

	function automatic cmd_t make_cmd(int s, int c, int l, int d);
		cmd_t x;
		x.system_number  = 5'(s);
		x.channel_number = 4'(c);
		x.dim_level      = 4'(l);
		x.dim_style      = 2'(d);
		return x;
	endfunction

	function automatic cmd_t random_cmd();
		logic [14:0] raw;
		cmd_t        x;
		raw = 15'($urandom);
		if ($urandom_range(0, 9) < 8)
			x = make_cmd($urandom_range(1, 16), $urandom_range(1, 10),
			             $urandom_range(0, 10), $urandom_range(0, 1));
		else
			x = raw;
		return x;
	endfunction

	// Hold start high until the transaction is taken
	task automatic send_cmd(cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic idle_for(int n);
		start <= 1'b0;
		cmd   <= random_cmd();
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		int waited;
		waited = 0;
		start <= 1'b0;
		while (frames.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_short_symbol(logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		frames.short_symbol = v;
	endtask

	task automatic run_random(int count);
		int sent;
		int burst;
		int gap;
		sent = 0;
		while (sent < count) begin
			burst = ($urandom_range(0, 9) == 0) ? 20 : $urandom_range(1, 6);
			for (int j = 0; j < burst && sent < count; j++) begin
				send_cmd(random_cmd());
				sent++;
			end
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
			if (gap > 0)
				idle_for(gap);
		end
	endtask

	initial begin
		cmd_t       directed[$];
		logic [7:0] settings[$];
		directed = '{
			make_cmd(1, 1, 0, 0),   make_cmd(16, 10, 10, 1), make_cmd(1, 9, 5, 1),
			make_cmd(8, 2, 1, 0),   make_cmd(9, 3, 2, 1),    make_cmd(2, 4, 3, 0),
			make_cmd(3, 5, 4, 1),   make_cmd(4, 6, 6, 0),    make_cmd(5, 7, 7, 1),
			make_cmd(6, 8, 8, 0),   make_cmd(7, 10, 9, 1),   make_cmd(15, 1, 0, 1),
			make_cmd(0, 1, 1, 0),   make_cmd(17, 1, 1, 0),   make_cmd(31, 15, 15, 3),
			make_cmd(1, 0, 1, 0),   make_cmd(1, 11, 1, 0),   make_cmd(1, 1, 11, 0),
			make_cmd(1, 1, 15, 1),  make_cmd(1, 1, 1, 2),    make_cmd(1, 1, 1, 3),
			make_cmd(16, 10, 10, 0)
		};
		settings = '{8'h00, 8'hFF, SYM_T, 8'($urandom), SHORT_RST};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset value of the short symbol first
		foreach (directed[i]) begin
			send_cmd(directed[i]);
			if (i % 5 == 4)
				idle_for($urandom_range(1, 40));
		end
		drain();

		foreach (settings[k]) begin
			write_short_symbol(settings[k]);
			run_random(44);
			drain();
		end

		frames.flag_leftovers();
		if (frames.fail_count == 0)
			$display("dimmer_rf_remote_code_encoder_tb: PASS");
		else
			$display("dimmer_rf_remote_code_encoder_tb: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("dimmer_rf_remote_code_encoder_tb: FAIL");
		$finish;
	end

endmodule
